@@ sv/wsh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wsh_pkg;

  // Wave table size and derived widths
  localparam int TRAIN_COUNT = 16;
  localparam int TIDX_W = (TRAIN_COUNT > 1) ? $clog2(TRAIN_COUNT) : 1;
  localparam int CNT_W = $clog2(TRAIN_COUNT + 1);

  // Shared multiplier: signed operands, full product
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;

  // Shared divider and square root widths
  localparam int DIV_W = 48;
  localparam int DVS_W = 32;
  localparam int SQ_IN_W = 64;
  localparam int SQ_OUT_W = SQ_IN_W / 2;

  // Request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_SEA_LEVEL = 2'd0;
  localparam logic [1:0] REG_WAVES_EN = 2'd1;
  localparam logic [1:0] REG_ACTIVE = 2'd2;

  // Turns per radian (1/(2*pi)), Q32
  localparam logic signed [MUL_W-1:0] INV_TWO_PI = 34'sd683565276;

  // Quarter-turn sine polynomial (Q30, Horner order)
  localparam logic signed [MUL_W-1:0] SIN_C0 = 34'sd172272;
  localparam logic signed [MUL_W-1:0] SIN_C1 = -34'sd5026995;
  localparam logic signed [MUL_W-1:0] SIN_C2 = 34'sd85569306;
  localparam logic signed [MUL_W-1:0] SIN_C3 = -34'sd693598668;
  localparam logic signed [MUL_W-1:0] SIN_C4 = 34'sd1686629713;

  // Quarter-turn cosine polynomial (Q30, Horner order)
  localparam logic signed [MUL_W-1:0] COS_C0 = -34'sd27058;
  localparam logic signed [MUL_W-1:0] COS_C1 = 34'sd987048;
  localparam logic signed [MUL_W-1:0] COS_C2 = -34'sd22401991;
  localparam logic signed [MUL_W-1:0] COS_C3 = 34'sd272375560;
  localparam logic signed [MUL_W-1:0] COS_C4 = -34'sd1324675879;

endpackage
`default_nettype wire

@@ sv/wsh_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wsh_mul (
  input  logic                               clk,
  input  logic signed [wsh_pkg::MUL_W-1:0]   a,
  input  logic signed [wsh_pkg::MUL_W-1:0]   b,
  output logic signed [wsh_pkg::PROD_W-1:0]  p
);
  import wsh_pkg::*;

  // Registered signed product
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

@@ sv/wsh_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wsh_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wsh_pkg::DIV_W-1:0]   dividend,
  input  logic [wsh_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [wsh_pkg::DIV_W-1:0]  quot
);
  import wsh_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [DVS_W:0]   rs;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle, restoring
  assign rs   = {rem[DVS_W-1:0], quot[DIV_W-1]};
  assign ge   = rs >= {1'b0, dvs};
  assign diff = rs - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DIV_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (run) begin
      rem  <= ge ? diff : rs;
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ sv/wsh_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wsh_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wsh_pkg::SQ_IN_W-1:0]    radicand,
  output logic                           done,
  output logic [wsh_pkg::SQ_OUT_W-1:0]   root
);
  import wsh_pkg::*;

  localparam int CW = $clog2(SQ_OUT_W + 1);
  localparam int RW = SQ_OUT_W + 4;

  logic [SQ_IN_W-1:0] sh;
  logic [RW-1:0]      rem;
  logic [CW-1:0]      cnt;
  logic               run;
  logic [RW-1:0]      rs;
  logic [RW-1:0]      trial;
  logic               ge;

  // Two radicand bits per cycle, one root bit
  assign rs    = {rem[RW-3:0], sh[SQ_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(SQ_OUT_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      sh   <= {sh[SQ_IN_W-3:0], 2'b00};
      rem  <= ge ? (rs - trial) : rs;
      root <= {root[SQ_OUT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ sv/wave_sum_height_normal.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sum-of-sines water surface: a load request (func 0) writes one wave train
// entry. An evaluate request (func 1) sums the active trains through one
// shared 34x34 multiplier, a serial divider and a serial square root, then
// returns height and unit normal with a one-cycle done strobe; the receiver
// cannot stall, so capture the result ports while done is high.
// Each resolvable train takes a divide for the resolution ratio plus 23
// multiplies, a skipped train only that divide (a single multiply with a
// tiny cell), and the normal up to 14 scaling steps, a root and three
// divides. busy is high for the whole evaluate; configuration writes are
// always ready.
module wave_sum_height_normal (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [3:0]  train_index,
  input  logic [31:0] train_amplitude,
  input  logic [31:0] train_kx,
  input  logic [31:0] train_kz,
  input  logic [31:0] train_phase,
  input  logic [31:0] train_wavelength,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_z,
  input  logic [16:0] taper,
  input  logic [31:0] cell_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] height,
  output logic [17:0] normal_x,
  output logic [16:0] normal_y,
  output logic [17:0] normal_z
);
  import wsh_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TRAIN = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_RES   = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_NORM  = 4'd5;
  localparam logic [3:0] ST_SCALE = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_NDIV  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // Multiply micro-ops
  localparam logic [4:0] OP_AMP = 5'd0;
  localparam logic [4:0] OP_RES = 5'd1;
  localparam logic [4:0] OP_KTX = 5'd2;
  localparam logic [4:0] OP_KTZ = 5'd3;
  localparam logic [4:0] OP_PXL = 5'd4;
  localparam logic [4:0] OP_PXH = 5'd5;
  localparam logic [4:0] OP_PZL = 5'd6;
  localparam logic [4:0] OP_PZH = 5'd7;
  localparam logic [4:0] OP_R2  = 5'd8;
  localparam logic [4:0] OP_S1  = 5'd9;
  localparam logic [4:0] OP_S2  = 5'd10;
  localparam logic [4:0] OP_S3  = 5'd11;
  localparam logic [4:0] OP_S4  = 5'd12;
  localparam logic [4:0] OP_S5  = 5'd13;
  localparam logic [4:0] OP_C1  = 5'd14;
  localparam logic [4:0] OP_C2  = 5'd15;
  localparam logic [4:0] OP_C3  = 5'd16;
  localparam logic [4:0] OP_C4  = 5'd17;
  localparam logic [4:0] OP_C5  = 5'd18;
  localparam logic [4:0] OP_HGT = 5'd19;
  localparam logic [4:0] OP_SLP = 5'd20;
  localparam logic [4:0] OP_DX  = 5'd21;
  localparam logic [4:0] OP_DZ  = 5'd22;
  localparam logic [4:0] OP_AX  = 5'd23;
  localparam logic [4:0] OP_AZ  = 5'd24;
  localparam logic [4:0] OP_ONE = 5'd25;
  localparam logic [4:0] OP_WL  = 5'd26;

  // Normal component select
  localparam logic [1:0] N_X = 2'd0;
  localparam logic [1:0] N_Y = 2'd1;
  localparam logic [1:0] N_Z = 2'd2;

  // Configuration
  logic signed [31:0] sea_level;
  logic               waves_en;
  logic [4:0]         active;

  // Wave table with per-entry valid bits
  logic [31:0]          tab_amp [TRAIN_COUNT];
  logic [31:0]          tab_kx  [TRAIN_COUNT];
  logic [31:0]          tab_kz  [TRAIN_COUNT];
  logic [31:0]          tab_ph  [TRAIN_COUNT];
  logic [31:0]          tab_wl  [TRAIN_COUNT];
  logic [TRAIN_COUNT-1:0] tvalid;

  // Control
  logic [3:0]       state;
  logic [4:0]       mop;
  logic             mph;
  logic [CNT_W-1:0] trn;
  logic [CNT_W-1:0] n_act;
  logic             launched;
  logic [1:0]       nsel;

  // Evaluate datapath
  logic signed [31:0] px;
  logic signed [31:0] pz;
  logic [16:0]        tap;
  logic [16:0]        tap_c;
  logic [31:0]        cell_sz;
  logic [47:0]        ratio;
  logic [16:0]        res;
  logic [31:0]        amp_a;
  logic [47:0]        ktx;
  logic [47:0]        ktz;
  logic [55:0]        pacc;
  logic [29:0]        r2;
  logic signed [MUL_W-1:0] t;
  logic [30:0]        sv;
  logic [30:0]        cv;
  logic signed [39:0] y;
  logic signed [MUL_W-1:0] sl;
  logic signed [47:0] dx;
  logic signed [47:0] dz;
  logic [47:0]        ax;
  logic [47:0]        az;
  logic [16:0]        one;
  logic [63:0]        sq;
  logic [31:0]        len;
  logic               negx;
  logic               negz;

  // Current entry
  logic [TIDX_W-1:0] ti;
  logic [31:0] e_amp, e_kx, e_kz, e_ph, e_wl;

  // Shared units
  logic signed [MUL_W-1:0]  ma;
  logic signed [MUL_W-1:0]  mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [37:0]       p30;
  logic [43:0]              p24;
  logic [PROD_W-1:0]        kt_sum;
  logic signed [MUL_W-1:0]  coef;
  logic [37:0]              tsum;
  logic [31:0]              sn;
  logic [31:0]              cs;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dnd;
  logic [DVS_W-1:0]         div_dvs;
  logic                     div_done;
  logic [DIV_W-1:0]         div_q;
  logic [16:0]              nc;
  logic [31:0]              ncomp;
  logic                     sq_start;
  logic                     sq_done;
  logic [SQ_OUT_W-1:0]      sq_root;

  function automatic logic [30:0] clamp30(input logic signed [37:0] v);
    if (v < 0) return 31'd0;
    else if (v > 38'sd1073741824) return 31'h4000_0000;
    else return v[30:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_OUT);

  assign tap_c = (taper > 17'd65536) ? 17'd65536 : taper;
  assign n_act = (32'(active) > TRAIN_COUNT) ? CNT_W'(TRAIN_COUNT) : CNT_W'(active);

  // Table read at the train counter; unwritten rows read as zero
  assign ti    = trn[TIDX_W-1:0];
  assign e_amp = tvalid[ti] ? tab_amp[ti] : 32'd0;
  assign e_kx  = tvalid[ti] ? tab_kx[ti]  : 32'd0;
  assign e_kz  = tvalid[ti] ? tab_kz[ti]  : 32'd0;
  assign e_ph  = tvalid[ti] ? tab_ph[ti]  : 32'd0;
  assign e_wl  = tvalid[ti] ? tab_wl[ti]  : 32'd0;

  // Product views
  assign p30    = prod[67:30];
  assign p24    = prod[67:24];
  assign kt_sum = prod + 68'sd32768;
  assign tsum   = p30 + {{4{coef[MUL_W-1]}}, coef};

  // Quadrant fold of sine and cosine
  always_comb begin
    case (pacc[55:54])
      2'd0:    begin sn = {1'b0, sv};         cs = {1'b0, cv};         end
      2'd1:    begin sn = {1'b0, cv};         cs = 32'd0 - {1'b0, sv}; end
      2'd2:    begin sn = 32'd0 - {1'b0, sv}; cs = 32'd0 - {1'b0, cv}; end
      default: begin sn = 32'd0 - {1'b0, cv}; cs = {1'b0, sv};         end
    endcase
  end

  // Polynomial coefficient added after each Horner multiply
  always_comb begin
    case (mop)
      OP_S1:   coef = SIN_C1;
      OP_S2:   coef = SIN_C2;
      OP_S3:   coef = SIN_C3;
      OP_S4:   coef = SIN_C4;
      OP_C1:   coef = COS_C1;
      OP_C2:   coef = COS_C2;
      OP_C3:   coef = COS_C3;
      OP_C4:   coef = COS_C4;
      default: coef = '0;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    case (mop) inside
      OP_AMP: begin ma = {2'b00, e_amp}; mb = {17'd0, tap}; end
      OP_RES: begin ma = {2'b00, amp_a}; mb = {17'd0, res}; end
      OP_KTX: begin ma = {{2{e_kx[31]}}, e_kx}; mb = INV_TWO_PI; end
      OP_KTZ: begin ma = {{2{e_kz[31]}}, e_kz}; mb = INV_TWO_PI; end
      OP_PXL: begin ma = {{2{px[31]}}, px}; mb = {2'b00, ktx[31:0]}; end
      OP_PXH: begin ma = {{2{px[31]}}, px}; mb = {{18{ktx[47]}}, ktx[47:32]}; end
      OP_PZL: begin ma = {{2{pz[31]}}, pz}; mb = {2'b00, ktz[31:0]}; end
      OP_PZH: begin ma = {{2{pz[31]}}, pz}; mb = {{18{ktz[47]}}, ktz[47:32]}; end
      OP_R2:  begin ma = {4'd0, pacc[53:24]}; mb = {4'd0, pacc[53:24]}; end
      OP_S1, OP_S2, OP_S3, OP_S4, OP_C1, OP_C2, OP_C3, OP_C4, OP_C5: begin
        ma = t;
        mb = {4'd0, r2};
      end
      OP_S5:  begin ma = t; mb = {4'd0, pacc[53:24]}; end
      OP_HGT: begin ma = {2'b00, amp_a}; mb = {{2{cs[31]}}, cs}; end
      OP_SLP: begin ma = {2'b00, amp_a}; mb = {{2{sn[31]}}, sn}; end
      OP_DX:  begin ma = sl; mb = {{2{e_kx[31]}}, e_kx}; end
      OP_DZ:  begin ma = sl; mb = {{2{e_kz[31]}}, e_kz}; end
      OP_AX:  begin ma = {4'd0, ax[29:0]}; mb = {4'd0, ax[29:0]}; end
      OP_AZ:  begin ma = {4'd0, az[29:0]}; mb = {4'd0, az[29:0]}; end
      OP_ONE: begin ma = {17'd0, one}; mb = {17'd0, one}; end
      OP_WL:  begin ma = {2'b00, e_wl}; mb = 34'sd10000; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  wsh_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  // Divider shared between resolution ratio and normal components
  always_comb begin
    case (nsel)
      N_X:     ncomp = ax[31:0];
      N_Y:     ncomp = {15'd0, one};
      default: ncomp = az[31:0];
    endcase
  end

  assign div_start = ((state == ST_DIV) || (state == ST_NDIV)) && !launched;
  assign div_dnd   = (state == ST_DIV) ? {e_wl, 16'd0}
                                       : ({ncomp, 16'd0} + {17'd0, len[31:1]});
  assign div_dvs   = (state == ST_DIV) ? cell_sz : len;
  assign nc        = (div_q > 48'd65536) ? 17'd65536 : div_q[16:0];

  wsh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dnd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  assign sq_start = (state == ST_SQRT) && !launched;

  wsh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sea_level <= '0;
      waves_en  <= 1'b1;
      active    <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEA_LEVEL: sea_level <= cfg_data;
        REG_WAVES_EN:  waves_en  <= cfg_data[0];
        REG_ACTIVE:    active    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mop      <= OP_AMP;
      mph      <= 1'b0;
      trn      <= '0;
      launched <= 1'b0;
      nsel     <= N_X;
      tvalid   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (func == FUNC_LOAD) begin
              if (32'(train_index) < TRAIN_COUNT) begin
                tab_amp[TIDX_W'(train_index)] <= train_amplitude;
                tab_kx[TIDX_W'(train_index)]  <= train_kx;
                tab_kz[TIDX_W'(train_index)]  <= train_kz;
                tab_ph[TIDX_W'(train_index)]  <= train_phase;
                tab_wl[TIDX_W'(train_index)]  <= train_wavelength;
                tvalid[TIDX_W'(train_index)]  <= 1'b1;
              end
            end else begin
              px      <= pos_x;
              pz      <= pos_z;
              tap     <= tap_c;
              cell_sz <= cell_size;
              y       <= {{8{sea_level[31]}}, sea_level};
              dx      <= '0;
              dz      <= '0;
              trn     <= '0;
              state <= (waves_en && (tap_c != 17'd0)) ? ST_TRAIN : ST_NORM;
            end
          end
        end

        ST_TRAIN: begin
          if (trn >= n_act) begin
            state <= ST_NORM;
          end else if (cell_sz < 32'd7) begin
            mop   <= OP_WL;
            mph   <= 1'b0;
            state <= ST_MUL;
          end else begin
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            launched <= 1'b0;
            ratio    <= div_q;
            state    <= ST_RES;
          end else begin
            launched <= 1'b1;
          end
        end

        // Resolution weight; unresolvable trains are skipped
        ST_RES: begin
          if (ratio <= 48'd98304) begin
            trn   <= trn + 1'b1;
            state <= ST_TRAIN;
          end else begin
            res   <= (ratio >= 48'd229376) ? 17'd65536
                                           : 17'((ratio - 48'd98304) >> 1);
            mop   <= OP_AMP;
            mph   <= 1'b0;
            state <= ST_MUL;
          end
        end

        // Each multiply presents its operands, then takes the registered product
        ST_MUL: begin
          mph <= !mph;
          if (mph) begin
            mop <= mop + 1'b1;
            case (mop) inside
              OP_AMP, OP_RES: amp_a <= prod[47:16];
              OP_KTX: ktx <= kt_sum[63:16];
              OP_KTZ: ktz <= kt_sum[63:16];
              OP_PXL: pacc <= {e_ph, 24'd0} + 56'h80_0000 - prod[55:0];
              OP_PZL: pacc <= pacc - prod[55:0];
              OP_PXH, OP_PZH: pacc <= pacc - {prod[23:0], 32'd0};
              OP_R2: begin
                r2 <= prod[59:30];
                t  <= SIN_C0;
              end
              OP_S1, OP_S2, OP_S3, OP_S4, OP_C1, OP_C2, OP_C3, OP_C4:
                t <= tsum[MUL_W-1:0];
              OP_S5: begin
                sv <= clamp30(p30);
                t  <= COS_C0;
              end
              OP_C5:  cv <= clamp30(p30 + 38'sd1073741824);
              OP_HGT: y  <= y + {{2{p30[37]}}, p30};
              OP_SLP: sl <= p30[MUL_W-1:0];
              OP_DX:  dx <= dx + {{4{p24[43]}}, p24};
              OP_DZ: begin
                dz    <= dz + {{4{p24[43]}}, p24};
                trn   <= trn + 1'b1;
                state <= ST_TRAIN;
              end
              OP_AX: sq <= prod[63:0];
              OP_AZ: sq <= sq + prod[63:0];
              OP_ONE: begin
                sq    <= sq + prod[63:0];
                state <= ST_SQRT;
              end
              OP_WL: begin
                ratio <= prod[47:0];
                state <= ST_RES;
              end
              default: ;
            endcase
          end
        end

        // Saturate height, take slope magnitudes
        ST_NORM: begin
          if (y > 40'sd2147483647) height <= 32'h7fff_ffff;
          else if (y < -40'sd2147483648) height <= 32'h8000_0000;
          else height <= y[31:0];
          negx  <= !dx[47] && (dx != 48'sd0);
          negz  <= !dz[47] && (dz != 48'sd0);
          ax    <= dx[47] ? (48'd0 - dx) : dx;
          az    <= dz[47] ? (48'd0 - dz) : dz;
          one   <= 17'd65536;
          state <= ST_SCALE;
        end

        // Halve until both slopes fit in 30 bits
        ST_SCALE: begin
          if ((ax[47:30] != '0) || (az[47:30] != '0)) begin
            ax  <= ax >> 1;
            az  <= az >> 1;
            one <= one >> 1;
          end else begin
            mop   <= OP_AX;
            mph   <= 1'b0;
            state <= ST_MUL;
          end
        end

        ST_SQRT: begin
          if (sq_done) begin
            launched <= 1'b0;
            len      <= (sq_root == '0) ? 32'd1 : sq_root;
            nsel     <= N_X;
            state    <= ST_NDIV;
          end else begin
            launched <= 1'b1;
          end
        end

        ST_NDIV: begin
          if (div_done) begin
            launched <= 1'b0;
            unique case (nsel)
              N_X: normal_x <= negx ? (18'd0 - {1'b0, nc}) : {1'b0, nc};
              N_Y: normal_y <= nc;
              default: normal_z <= negz ? (18'd0 - {1'b0, nc}) : {1'b0, nc};
            endcase
            if (nsel == N_Z) state <= ST_OUT;
            else nsel <= nsel + 1'b1;
          end else begin
            launched <= 1'b1;
          end
        end

        ST_OUT: state <= ST_IDLE;

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_LOAD)) |=> !busy)
    else $error("load request did not complete in one cycle");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_EVAL)) |=> (busy && !done))
    else $error("evaluate request did not hold busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result strobe");

  a_ny_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_y <= 17'd65536))
    else $error("normal_y above one");
`endif

endmodule
`default_nettype wire
